// File: design/sta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types and constants for the sorted term accumulator.
// ----------------------------------------------------------------------------
package sta_pkg;

    localparam int DEF_MAX_TERMS = 32;
    localparam int EXP_W         = 16;
    localparam int COEFF_W       = 32;
    localparam int COUNT_OUT_W   = 6;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_MERGED    = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_FULL      = 3'd3,
        ST_IGNORED   = 3'd4,
        ST_READ      = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef struct packed {
        t_func                func;
        logic [COEFF_W-1:0]   in_coeff;
        logic [EXP_W-1:0]     in_exp;
    } t_in_item;

    typedef struct packed {
        logic [COEFF_W-1:0]     out_coeff;
        logic [EXP_W-1:0]       out_exp;
        logic                   last;
        t_status                status;
        logic [COUNT_OUT_W-1:0] term_count;
    } t_out_item;

    typedef struct packed {
        logic [EXP_W-1:0]   exp;
        logic [COEFF_W-1:0] coeff;
    } t_term;

endpackage
`default_nettype wire

// File: design/sta_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sta_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: design/sorted_term_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_term_accumulator
// Table of polynomial terms kept sorted by exponent, highest first, in a RAM.
// Add merges or inserts a term, read streams all terms, clear empties it.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------
//  in       | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//
//  One item is worked at a time; o_in_stall is high until its last result
//  sits in the output register. All table work goes through the single RAM
//  read and write port: an add scans each entry above its slot, then
//  moves each entry that it shifts; a read fetches the terms in order.
//  Clear, ignored and empty items skip to S_RESP. Reset empties the table.
//  A stalled output holds the sequencer only where it posts a result.
// ----------------------------------------------------------------------------
module sorted_term_accumulator #(
    parameter int MAX_TERMS = sta_pkg::DEF_MAX_TERMS,
    localparam int AW       = $clog2(MAX_TERMS),
    localparam int CW       = $clog2(MAX_TERMS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire sta_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output sta_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SRCH  = 11'b000_0000_0010,
        S_SCMP  = 11'b000_0000_0100,
        S_UPCK  = 11'b000_0000_1000,
        S_UPWR  = 11'b000_0001_0000,
        S_DNCK  = 11'b000_0010_0000,
        S_DNWR  = 11'b000_0100_0000,
        S_RDRQ  = 11'b000_1000_0000,
        S_RDOUT = 11'b001_0000_0000,
        S_RESP  = 11'b010_0000_0000,
        S_SPARE = 11'b100_0000_0000
    } t_state;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx,   n_idx;
    logic [CW-1:0]             r_j,     n_j;
    logic [sta_pkg::COEFF_W-1:0] r_coeff, n_coeff;
    logic [sta_pkg::EXP_W-1:0]   r_exp,   n_exp;
    sta_pkg::t_status          r_status, n_status;
    logic                      r_out_valid, n_out_valid;
    sta_pkg::t_out_item        r_out, n_out;

    logic                      w_wr_en, w_rd_en;
    logic [AW-1:0]             w_wr_addr, w_rd_addr;
    sta_pkg::t_term            w_wr_data, w_rd_data;
    logic                      w_out_free;
    logic                      w_full;
    logic [CW:0]               w_j_inc;
    logic [CW:0]               w_idx_inc;
    logic [sta_pkg::COEFF_W:0] w_sum;
    logic [sta_pkg::COEFF_W-1:0] w_sat;

    sta_ram #(
        .WIDTH ($bits(sta_pkg::t_term)),
        .DEPTH (MAX_TERMS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count == CW'(MAX_TERMS));
    assign w_j_inc    = {1'b0, r_j} + (CW+1)'(1);
    assign w_idx_inc  = {1'b0, r_idx} + (CW+1)'(1);

    // shared adder with signed saturation
    assign w_sum = {w_rd_data.coeff[sta_pkg::COEFF_W-1], w_rd_data.coeff}
                 + {r_coeff[sta_pkg::COEFF_W-1], r_coeff};
    always_comb begin
        if (w_sum[sta_pkg::COEFF_W] != w_sum[sta_pkg::COEFF_W-1]) begin
            w_sat = {w_sum[sta_pkg::COEFF_W], {(sta_pkg::COEFF_W-1){!w_sum[sta_pkg::COEFF_W]}}};
        end else begin
            w_sat = w_sum[sta_pkg::COEFF_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_j         = r_j;
        n_coeff     = r_coeff;
        n_exp       = r_exp;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx[AW-1:0];
        w_wr_data   = '{exp: r_exp, coeff: r_coeff};
        w_rd_en     = 1'b0;
        w_rd_addr   = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_coeff = i_in_data.in_coeff;
                    n_exp   = i_in_data.in_exp;
                    n_idx   = '0;
                    unique case (i_in_data.func)
                        sta_pkg::FUNC_ADD: begin
                            if (i_in_data.in_coeff == '0) begin
                                n_status = sta_pkg::ST_IGNORED;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        sta_pkg::FUNC_READ: begin
                            if (r_count == '0) begin
                                n_status = sta_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_RDRQ;
                            end
                        end
                        sta_pkg::FUNC_CLEAR: begin
                            n_count  = '0;
                            n_status = sta_pkg::ST_EMPTY;
                            n_state  = S_RESP;
                        end
                        default: begin
                            n_status = sta_pkg::ST_IGNORED;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (r_idx >= r_count) begin
                    // ran past the end: new term goes last
                    if (w_full) begin
                        n_status = sta_pkg::ST_FULL;
                        n_state  = S_RESP;
                    end else begin
                        n_j     = r_count;
                        n_state = S_UPCK;
                    end
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (w_rd_data.exp > r_exp) begin
                    n_idx   = w_idx_inc[CW-1:0];
                    n_state = S_SRCH;
                end else if (w_rd_data.exp == r_exp) begin
                    if (w_sum == '0) begin
                        n_j     = r_idx;
                        n_state = S_DNCK;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_data = '{exp: r_exp, coeff: w_sat};
                        n_status  = sta_pkg::ST_MERGED;
                        n_state   = S_RESP;
                    end
                end else if (w_full) begin
                    n_status = sta_pkg::ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_j     = r_count;
                    n_state = S_UPCK;
                end
            end
            S_UPCK: begin
                // open a slot at r_idx by moving entries up one place
                if (r_j > r_idx) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(r_j - CW'(1));
                    n_state   = S_UPWR;
                end else begin
                    w_wr_en  = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_status = sta_pkg::ST_INSERTED;
                    n_state  = S_RESP;
                end
            end
            S_UPWR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_j[AW-1:0];
                w_wr_data = w_rd_data;
                n_j       = r_j - CW'(1);
                n_state   = S_UPCK;
            end
            S_DNCK: begin
                // close the gap at r_j by moving entries down one place
                if (w_j_inc < {1'b0, r_count}) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_j_inc[AW-1:0];
                    n_state   = S_DNWR;
                end else begin
                    n_count  = r_count - CW'(1);
                    n_status = sta_pkg::ST_CANCELLED;
                    n_state  = S_RESP;
                end
            end
            S_DNWR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_j[AW-1:0];
                w_wr_data = w_rd_data;
                n_j       = w_j_inc[CW-1:0];
                n_state   = S_DNCK;
            end
            S_RDRQ: begin
                w_rd_en = 1'b1;
                n_state = S_RDOUT;
            end
            S_RDOUT: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.out_coeff  = w_rd_data.coeff;
                    n_out.out_exp    = w_rd_data.exp;
                    n_out.last       = (w_idx_inc == {1'b0, r_count});
                    n_out.status     = sta_pkg::ST_READ;
                    n_out.term_count = sta_pkg::COUNT_OUT_W'(r_count);
                    n_idx            = w_idx_inc[CW-1:0];
                    n_state          = (w_idx_inc == {1'b0, r_count}) ? S_IDLE : S_RDRQ;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.out_coeff  = '0;
                    n_out.out_exp    = '0;
                    n_out.last       = 1'b1;
                    n_out.status     = r_status;
                    n_out.term_count = sta_pkg::COUNT_OUT_W'(r_count);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_coeff  <= n_coeff;
        r_exp    <= n_exp;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
